>>> rtl/nlw_pkg.sv
// ============================================================================
// nlw_pkg
// Shared types and constants for the nearest-landmark-within-radius block:
// point format, operation codes, register map, cell controls and FSM states.
// ============================================================================
package nlw_pkg;

    // Coordinate and register widths (fixed by the item format)
    localparam int COORD_W   = 16;
    localparam int GATE_W    = 15;
    localparam int GATE_SQ_W = 2 * GATE_W;
    localparam int SQ_W      = 2 * COORD_W;   // |dx|^2 fits in 32 bits
    localparam int D2_W      = SQ_W + 1;      // dx^2 + dy^2
    localparam int OUT_IDX_W = 6;

    // Operation codes carried in the op field
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register map (register index is paddr[2])
    localparam logic REG_GATE_RADIUS = 1'b0;
    localparam logic [GATE_W-1:0] GATE_RADIUS_RESET = 15'd256;

    // One landmark point in signed Q8.8
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    // Per-cell controls of the landmark ring
    typedef struct packed {
        logic shift;   // take the neighbor's point
        logic load;    // take the appended point
    } cell_ctrl_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

>>> rtl/nlw_cell.sv
// ============================================================================
// nlw_cell
// One storage cell of the landmark ring: holds a single point, takes an
// appended point on load, or takes its neighbor's point while the ring turns.
// ============================================================================
module nlw_cell
    import nlw_pkg::*;
(
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  point_t     load_pt,
    input  point_t     nbr_pt,
    output point_t     pt
);

    point_t pt_reg;
    point_t pt_next;

    // Load wins over shift; both never occur together
    always_comb begin
        pt_next = pt_reg;
        if (ctrl.load) begin
            pt_next = load_pt;
        end else if (ctrl.shift) begin
            pt_next = nbr_pt;
        end
    end

    always_ff @(posedge aclk) begin
        pt_reg <= pt_next;
    end

    assign pt = pt_reg;

endmodule

>>> rtl/nlw_dist.sv
// ============================================================================
// nlw_dist
// Pipelined squared-distance unit with running-best tracking. Takes one
// landmark per cycle at the ring head: subtract, square, sum, then compare
// against the gate and the best so far (earliest index wins on ties).
// ============================================================================
module nlw_dist
    import nlw_pkg::*;
#(
    parameter int IDX_W = 6
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  clear,
    input  logic                  in_valid,
    input  logic [IDX_W-1:0]      in_idx,
    input  point_t                in_pt,
    input  point_t                query_pt,
    input  logic [GATE_SQ_W-1:0]  gate_sq,
    output logic                  best_hit,
    output logic [IDX_W-1:0]      best_idx,
    output point_t                best_pt
);

    // Stage 1: coordinate differences
    logic                        v1_reg;
    logic [IDX_W-1:0]            idx1_reg;
    point_t                      pt1_reg;
    logic signed [COORD_W:0]     dx1_reg, dy1_reg;
    logic signed [COORD_W:0]     dx1_next, dy1_next;

    // Stage 2: squares
    logic                        v2_reg;
    logic [IDX_W-1:0]            idx2_reg;
    point_t                      pt2_reg;
    logic [SQ_W-1:0]             sx2_reg, sy2_reg;
    logic signed [2*COORD_W+1:0] px_prod, py_prod;

    // Stage 3: sum
    logic                        v3_reg;
    logic [IDX_W-1:0]            idx3_reg;
    point_t                      pt3_reg;
    logic [D2_W-1:0]             d2_3_reg;
    logic [D2_W-1:0]             d2_3_next;

    // Running best
    logic                        hit_reg;
    logic [IDX_W-1:0]            best_idx_reg;
    point_t                      best_pt_reg;
    logic [D2_W-1:0]             best_d2_reg;
    logic                        take;

    assign dx1_next = {in_pt.x[COORD_W-1], in_pt.x} - {query_pt.x[COORD_W-1], query_pt.x};
    assign dy1_next = {in_pt.y[COORD_W-1], in_pt.y} - {query_pt.y[COORD_W-1], query_pt.y};

    assign px_prod = dx1_reg * dx1_reg;
    assign py_prod = dy1_reg * dy1_reg;

    assign d2_3_next = {1'b0, sx2_reg} + {1'b0, sy2_reg};

    // Strictly inside the gate and strictly better than the current best
    assign take = v3_reg
               && (d2_3_reg < D2_W'(gate_sq))
               && (!hit_reg || (d2_3_reg < best_d2_reg));

    // Pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge aclk) begin
        idx1_reg <= in_idx;
        pt1_reg  <= in_pt;
        dx1_reg  <= dx1_next;
        dy1_reg  <= dy1_next;
        idx2_reg <= idx1_reg;
        pt2_reg  <= pt1_reg;
        sx2_reg  <= px_prod[SQ_W-1:0];
        sy2_reg  <= py_prod[SQ_W-1:0];
        idx3_reg <= idx2_reg;
        pt3_reg  <= pt2_reg;
        d2_3_reg <= d2_3_next;
    end

    // Best-match flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (clear) begin
            hit_reg <= 1'b0;
        end else if (take) begin
            hit_reg <= 1'b1;
        end
    end

    // Best-match payload
    always_ff @(posedge aclk) begin
        if (take) begin
            best_idx_reg <= idx3_reg;
            best_pt_reg  <= pt3_reg;
            best_d2_reg  <= d2_3_reg;
        end
    end

    assign best_hit = hit_reg;
    assign best_idx = best_idx_reg;
    assign best_pt  = best_pt_reg;

endmodule

>>> rtl/nearest_landmark_within_radius_top.sv
// ============================================================================
// nearest_landmark_within_radius_top
// Landmark table with gated nearest-neighbor query.
//
// Landmarks live in a ring of MAX_LANDMARKS cells. A load transaction appends
// a point (or flags a drop when the table is full) and its acknowledge
// passes through the DONE state into the output register. A query turns the
// ring once, so every cell hands its point to its neighbor each cycle and the
// ring head feeds one landmark per cycle, in index order, into a single
// pipelined squared-distance unit; the result then waits in the DRAIN state
// while the last landmark passes the unit's difference, square, sum and
// best-match registers. One transaction is processed at a time; a new one is
// accepted while the previous result still waits in the output register.
// Distances are compared squared and exactly against gate_radius^2; ties keep
// the lowest index. No clearing pass is needed after reset.
// ============================================================================
module nearest_landmark_within_radius_top
    import nlw_pkg::*;
#(
    parameter int MAX_LANDMARKS = 64
)
(
    input  logic                      aclk,
    input  logic                      aresetn,

    // Input channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_op,
    input  logic signed [COORD_W-1:0] s_point_x,
    input  logic signed [COORD_W-1:0] s_point_y,

    // Result channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_is_query,
    output logic                      m_found,
    output logic signed [COORD_W-1:0] m_match_x,
    output logic signed [COORD_W-1:0] m_match_y,
    output logic [OUT_IDX_W-1:0]      m_match_index,
    output logic                      m_load_dropped,

    // Configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int IDX_W = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
    localparam int CNT_W = $clog2(MAX_LANDMARKS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_LANDMARKS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_LANDMARKS);
    localparam logic [1:0]       DRAIN_CYCLES = 2'd3;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [GATE_W-1:0]    gate_reg;
    logic [GATE_SQ_W-1:0] gate_sq_reg;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_reg <= GATE_RADIUS_RESET;
        end else if (cfg_wr && (paddr[2] == REG_GATE_RADIUS)) begin
            gate_reg <= pwdata[GATE_W-1:0];
        end
    end

    // Squared gate, one multiply registered
    always_ff @(posedge aclk) begin
        gate_sq_reg <= gate_reg * gate_reg;
    end

    // Register readback
    always_comb begin
        unique case (paddr[2])
            REG_GATE_RADIUS: prdata = {{(32 - GATE_W){1'b0}}, gate_reg};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  scan_reg, scan_next;
    logic [1:0]        drain_reg, drain_next;
    logic [CNT_W-1:0]  count_reg;
    logic              query_reg, drop_reg;
    point_t            query_pt_reg;

    logic              accept;
    logic              full;
    logic              wr_en;
    logic              shift_en;
    logic              issue_en;
    logic              out_load;
    logic              out_free;

    assign accept   = s_valid && s_ready;
    assign full     = (count_reg == FULL_CNT);
    assign wr_en    = accept && (s_op == OP_LOAD) && !full;
    assign out_free = !m_valid || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        scan_next  = scan_reg;
        drain_next = drain_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    scan_next  = '0;
                    state_next = (s_op == OP_QUERY) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                scan_next = scan_reg + 1'b1;
                if (scan_reg == LAST_IDX) begin
                    drain_next = DRAIN_CYCLES;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                drain_next = drain_reg - 1'b1;
                if (drain_reg == 2'd1) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready  = 1'b0;
        shift_en = 1'b0;
        issue_en = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_ready = 1'b1;
            ST_SCAN: begin
                shift_en = 1'b1;
                issue_en = 1'b1;
            end
            ST_DRAIN: ;
            ST_DONE:  out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            scan_reg  <= '0;
            drain_reg <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            drain_reg <= drain_next;
            if (wr_en) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Per-transaction context
    always_ff @(posedge aclk) begin
        if (accept) begin
            query_reg      <= (s_op == OP_QUERY);
            drop_reg       <= (s_op == OP_LOAD) && full;
            query_pt_reg.x <= s_point_x;
            query_pt_reg.y <= s_point_y;
        end
    end

    // ------------------------------------------------------------------
    // Landmark ring
    // ------------------------------------------------------------------
    point_t           ring [MAX_LANDMARKS];
    point_t           load_pt;
    logic [IDX_W-1:0] wr_addr;

    assign load_pt.x = s_point_x;
    assign load_pt.y = s_point_y;
    assign wr_addr   = count_reg[IDX_W-1:0];

    for (genvar i = 0; i < MAX_LANDMARKS; i++) begin : g_cell
        localparam int NXT = (i + 1) % MAX_LANDMARKS;
        cell_ctrl_t ctrl;

        assign ctrl.shift = shift_en;
        assign ctrl.load  = wr_en && (wr_addr == IDX_W'(i));

        nlw_cell u_cell (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .load_pt (load_pt),
            .nbr_pt  (ring[NXT]),
            .pt      (ring[i])
        );
    end

    // ------------------------------------------------------------------
    // Distance unit at the ring head
    // ------------------------------------------------------------------
    logic             issue_valid;
    logic             best_hit;
    logic [IDX_W-1:0] best_idx;
    point_t           best_pt;

    assign issue_valid = issue_en && (CNT_W'(scan_reg) < count_reg);

    nlw_dist #(
        .IDX_W (IDX_W)
    ) u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (accept),
        .in_valid (issue_valid),
        .in_idx   (scan_reg),
        .in_pt    (ring[0]),
        .query_pt (query_pt_reg),
        .gate_sq  (gate_sq_reg),
        .best_hit (best_hit),
        .best_idx (best_idx),
        .best_pt  (best_pt)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                  m_valid_reg;
    logic                  is_query_reg, found_reg, dropped_reg;
    point_t                match_pt_reg;
    logic [OUT_IDX_W-1:0]  match_idx_reg;
    logic                  hit_q;
    logic [IDX_W+OUT_IDX_W-1:0] idx_ext;

    assign hit_q   = query_reg && best_hit;
    assign idx_ext = {{OUT_IDX_W{1'b0}}, best_idx};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            is_query_reg  <= query_reg;
            found_reg     <= hit_q;
            dropped_reg   <= !query_reg && drop_reg;
            match_pt_reg  <= hit_q ? best_pt : '0;
            match_idx_reg <= hit_q ? idx_ext[OUT_IDX_W-1:0] : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_is_query     = is_query_reg;
    assign m_found        = found_reg;
    assign m_match_x      = match_pt_reg.x;
    assign m_match_y      = match_pt_reg.y;
    assign m_match_index  = match_idx_reg;
    assign m_load_dropped = dropped_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Table count never passes the capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("landmark count beyond capacity");

    // An accepted load into a non-full table bumps the count by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_op == OP_LOAD) && !full) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("load did not append");

    // A finished transaction reaches the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DONE) && out_free) |=> m_valid)
        else $error("result lost at completion");

    // Only query results can report a match, and only load results can carry a drop flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_found && !m_is_query) && !(m_load_dropped && m_is_query))
        else $error("result flags inconsistent with transaction kind");

endmodule
